@@ hw/rtl/sfdm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdm_pkg
// Types and codes shared by the shadow frame mirror and its pixel stores.
// ----------------------------------------------------------------------------
package sfdm_pkg;

    localparam int unsigned COL_W  = 4;
    localparam int unsigned ROW_W  = 3;
    localparam int unsigned LCOL_W = 3;
    localparam int unsigned WADDR_W = COL_W + ROW_W;
    localparam int unsigned SADDR_W = LCOL_W + ROW_W;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_SCROLL = 2'd1,
        REQ_MIRROR = 2'd2,
        REQ_INIT   = 2'd3
    } req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] intensity;
    } pix_t;

    localparam pix_t PIX_ZERO = '{red: 8'h00, green: 8'h00, blue: 8'h00, intensity: 8'h00};
    localparam pix_t PIX_FULL = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, intensity: 8'hFF};

    typedef struct packed {
        req_t              req_type;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [7:0]        red_in;
        logic [7:0]        green_in;
        logic [7:0]        blue_in;
        logic [7:0]        intensity_in;
    } in_t;

    typedef struct packed {
        logic [LCOL_W-1:0] led_column;
        logic [ROW_W-1:0]  led_row;
        logic [7:0]        red_out;
        logic [7:0]        green_out;
        logic [7:0]        blue_out;
        logic [7:0]        intensity_out;
        logic              last_update;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_MIR_RD,
        ST_MIR_CMP,
        ST_FLUSH
    } state_t;

endpackage

@@ hw/rtl/sfdm_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdm_store
// Pixel memory with registered read and per-entry valid bits; an entry that
// was never written since reset or the last clear reads as RESET_PIX.
// ----------------------------------------------------------------------------
module sfdm_store #(
    parameter int unsigned ADDR_W = 6,
    parameter logic [31:0] RESET_PIX = 32'h0000_0000
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clr,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  sfdm_pkg::pix_t      wdata,
    input  logic                re,
    input  logic [ADDR_W-1:0]   raddr,
    output sfdm_pkg::pix_t      rdata
);
    import sfdm_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_W;

    pix_t               mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    pix_t               rd_data_reg;
    logic               rd_valid_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : pix_t'(RESET_PIX);

endmodule

@@ hw/rtl/shadow_frame_diff_mirror.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_frame_diff_mirror
// Working frame plus LED shadow; emits LED updates for changed pixels.
// ----------------------------------------------------------------------------
// A write beat stores one pixel of the 2*DISP_WIDTH x DISP_HEIGHT working
// frame; writes outside the frame are dropped. A mirror beat scans the
// visible DISP_WIDTH columns, column-major with the row inner, with one
// memory read and then one compare on a single comparator per pixel; an
// update that finds the previous one still waiting for the output register
// holds the scan. A scroll beat first moves columns 1 to 2*DISP_WIDTH-1 one
// place left, with one read and then one write of the working frame per
// pixel, then mirrors. An init beat clears both frames through their valid
// bits and mirrors. The input stalls for the whole of a scan. One update is
// held back in a pending slot so that the final one of a beat can carry
// last_update.
// ----------------------------------------------------------------------------
module shadow_frame_diff_mirror #(
    parameter int unsigned DISP_WIDTH  = 8,
    parameter int unsigned DISP_HEIGHT = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sfdm_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output sfdm_pkg::out_t  out_data
);
    import sfdm_pkg::*;

    localparam logic [ROW_W-1:0] ROW_LAST     = ROW_W'(DISP_HEIGHT - 1);
    localparam logic [COL_W-1:0] COL_LAST_VIS = COL_W'(DISP_WIDTH - 1);
    localparam logic [COL_W-1:0] COL_LAST_FRM = COL_W'(2 * DISP_WIDTH - 1);

    state_t             state_reg, state_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    out_t               pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    out_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    // store controls
    logic               clr_all;
    logic               wf_we;
    logic [WADDR_W-1:0] wf_waddr;
    pix_t               wf_wdata;
    logic               wf_re;
    pix_t               wf_rdata;
    logic               sf_we;
    logic               sf_re;
    pix_t               sf_rdata;

    logic               in_take;
    logic               out_free;
    logic               diff;
    logic               scan_last;

    sfdm_store #(
        .ADDR_W    (WADDR_W),
        .RESET_PIX (PIX_ZERO)
    ) u_work (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (clr_all),
        .we    (wf_we),
        .waddr (wf_waddr),
        .wdata (wf_wdata),
        .re    (wf_re),
        .raddr ({col_reg, row_reg}),
        .rdata (wf_rdata)
    );

    sfdm_store #(
        .ADDR_W    (SADDR_W),
        .RESET_PIX (PIX_FULL)
    ) u_shadow (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (clr_all),
        .we    (sf_we),
        .waddr ({col_reg[LCOL_W-1:0], row_reg}),
        .wdata (wf_rdata),
        .re    (sf_re),
        .raddr ({col_reg[LCOL_W-1:0], row_reg}),
        .rdata (sf_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign diff      = (wf_rdata != sf_rdata);
    assign scan_last = (col_reg == COL_LAST_VIS) && (row_reg == ROW_LAST);

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        clr_all         = 1'b0;
        wf_we           = 1'b0;
        wf_waddr        = {col_reg, row_reg};
        wf_wdata        = wf_rdata;
        wf_re           = 1'b0;
        sf_we           = 1'b0;
        sf_re           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    row_next = '0;
                    case (in_data.req_type)
                        REQ_WRITE:
                        begin
                            // drop writes outside the frame
                            wf_we    = (in_data.column <= COL_LAST_FRM) &&
                                       (in_data.row <= ROW_LAST);
                            wf_waddr = {in_data.column, in_data.row};
                            wf_wdata = '{red:       in_data.red_in,
                                         green:     in_data.green_in,
                                         blue:      in_data.blue_in,
                                         intensity: in_data.intensity_in};
                        end
                        REQ_SCROLL:
                        begin
                            col_next   = COL_W'(1);
                            state_next = ST_SCR_RD;
                        end
                        REQ_MIRROR:
                        begin
                            col_next   = '0;
                            state_next = ST_MIR_RD;
                        end
                        REQ_INIT:
                        begin
                            clr_all    = 1'b1;
                            col_next   = '0;
                            state_next = ST_MIR_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCR_RD:
            begin
                wf_re      = 1'b1;
                state_next = ST_SCR_WR;
            end

            ST_SCR_WR:
            begin
                // column c lands in column c-1
                wf_we    = 1'b1;
                wf_waddr = {col_reg - COL_W'(1), row_reg};
                if (row_reg == ROW_LAST)
                begin
                    row_next = '0;
                    if (col_reg == COL_LAST_FRM)
                    begin
                        col_next   = '0;
                        state_next = ST_MIR_RD;
                    end
                    else
                    begin
                        col_next   = col_reg + COL_W'(1);
                        state_next = ST_SCR_RD;
                    end
                end
                else
                begin
                    row_next   = row_reg + ROW_W'(1);
                    state_next = ST_SCR_RD;
                end
            end

            ST_MIR_RD:
            begin
                wf_re      = 1'b1;
                sf_re      = 1'b1;
                state_next = ST_MIR_CMP;
            end

            ST_MIR_CMP:
            begin
                if (!diff || !pend_valid_reg || out_free)
                begin
                    if (diff)
                    begin
                        // push the held update out, hold the new one back
                        if (pend_valid_reg)
                        begin
                            out_next             = pend_reg;
                            out_next.last_update = 1'b0;
                            out_valid_next       = 1'b1;
                        end
                        pend_next = '{led_column:    col_reg[LCOL_W-1:0],
                                      led_row:       row_reg,
                                      red_out:       wf_rdata.red,
                                      green_out:     wf_rdata.green,
                                      blue_out:      wf_rdata.blue,
                                      intensity_out: wf_rdata.intensity,
                                      last_update:   1'b0};
                        pend_valid_next = 1'b1;
                        sf_we           = 1'b1;
                    end
                    // advance the scan
                    if (scan_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (row_reg == ROW_LAST)
                    begin
                        row_next   = '0;
                        col_next   = col_reg + COL_W'(1);
                        state_next = ST_MIR_RD;
                    end
                    else
                    begin
                        row_next   = row_reg + ROW_W'(1);
                        state_next = ST_MIR_RD;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next             = pend_reg;
                    out_next.last_update = 1'b1;
                    out_valid_next       = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ bench/tb_shadow_frame_diff_mirror.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shadow_frame_diff_mirror
// Self-checking bench for the shadow frame mirror.
// ----------------------------------------------------------------------------
// Drives pixel writes, mirrors, scrolls and inits into the block and keeps its
// own copy of the working frame and the LED shadow. Every accepted beat is run
// through that copy, and the LED updates it predicts are queued in order. Each
// update the block hands out is compared field by field with the oldest one
// in the queue. Directed tests come first, then random traffic under three
// mixes of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_shadow_frame_diff_mirror;

    import sfdm_pkg::*;

    localparam int unsigned DISP_W     = 8;
    localparam int unsigned DISP_H     = 8;
    localparam int unsigned FRAME_COLS = 2 * DISP_W;
    // Longest idle stretch of the block after its last update: a full
    // scroll pass plus a scan, with margin.
    localparam int unsigned DRAIN_CYCLES = 600;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    shadow_frame_diff_mirror #(
        .DISP_WIDTH  (DISP_W),
        .DISP_HEIGHT (DISP_H)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Frame model: working frame, LED shadow and the queue of LED updates
    // still owed by the block.
    // ------------------------------------------------------------------
    pix_t frame_work  [FRAME_COLS][DISP_H];
    pix_t frame_shown [DISP_W][DISP_H];
    out_t led_expect [$];

    int fail_count    = 0;
    int beat_count    = 0;
    int update_count  = 0;
    int req_count [4] = '{0, 0, 0, 0};

    // Idle and stall odds, in percent, set per test phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    task automatic reset_frames();
        for (int c = 0; c < FRAME_COLS; c++)
            for (int y = 0; y < DISP_H; y++)
                frame_work[c][y] = PIX_ZERO;
        for (int c = 0; c < DISP_W; c++)
            for (int y = 0; y < DISP_H; y++)
                frame_shown[c][y] = PIX_FULL;
    endtask

    // Apply one accepted beat to the frame model and queue the LED updates
    // it causes. The newest update is held back so the final one of the
    // beat can be flagged with last_update.
    task automatic apply_beat(input in_t beat);
        out_t held;
        bit   have_held;
        pix_t p;
        have_held = 1'b0;
        case (beat.req_type)
            REQ_WRITE:
            begin
                if (beat.column < FRAME_COLS && beat.row < DISP_H)
                    frame_work[beat.column][beat.row] =
                        '{red: beat.red_in, green: beat.green_in,
                          blue: beat.blue_in, intensity: beat.intensity_in};
                return;
            end
            REQ_SCROLL:
            begin
                // Shift left by one column; the last column stays put.
                for (int c = 1; c < FRAME_COLS; c++)
                    for (int y = 0; y < DISP_H; y++)
                        frame_work[c-1][y] = frame_work[c][y];
            end
            REQ_INIT:
            begin
                reset_frames();
            end
            default:
            begin
            end
        endcase
        // Mirror: columns outer, rows inner.
        for (int c = 0; c < DISP_W; c++)
        begin
            for (int y = 0; y < DISP_H; y++)
            begin
                p = frame_work[c][y];
                if (p != frame_shown[c][y])
                begin
                    if (have_held)
                        led_expect.push_back(held);
                    held.led_column    = LCOL_W'(c);
                    held.led_row       = ROW_W'(y);
                    held.red_out       = p.red;
                    held.green_out     = p.green;
                    held.blue_out      = p.blue;
                    held.intensity_out = p.intensity;
                    held.last_update   = 1'b0;
                    have_held          = 1'b1;
                    frame_shown[c][y]  = p;
                end
            end
        end
        if (have_held)
        begin
            held.last_update = 1'b1;
            led_expect.push_back(held);
        end
    endtask

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------
    function automatic in_t pixel_beat(input int col, input int row, input pix_t p);
        in_t b;
        b.req_type     = REQ_WRITE;
        b.column       = COL_W'(col);
        b.row          = ROW_W'(row);
        b.red_in       = p.red;
        b.green_in     = p.green;
        b.blue_in      = p.blue;
        b.intensity_in = p.intensity;
        return b;
    endfunction

    // Non-write beats carry random junk in the pixel fields; the block
    // must ignore it.
    function automatic in_t cmd_beat(input req_t req);
        in_t b;
        b.req_type     = req;
        b.column       = COL_W'($urandom_range(FRAME_COLS - 1));
        b.row          = ROW_W'($urandom_range(DISP_H - 1));
        b.red_in       = 8'($urandom);
        b.green_in     = 8'($urandom);
        b.blue_in      = 8'($urandom);
        b.intensity_in = 8'($urandom);
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Sender: idle at random, then hold the beat until it is accepted.
    // Valid is left high after acceptance so back-to-back beats never see
    // two assignments to it in one step; drop_valid lowers it.
    // ------------------------------------------------------------------
    task automatic send_beat(input in_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_beat(beat);
        beat_count++;
        req_count[beat.req_type]++;
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall at random with the current odds.
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // ------------------------------------------------------------------
    // Update checker: compare each accepted LED update with the oldest
    // expected one.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            update_count++;
            if (led_expect.size() == 0)
            begin
                $error("LED update with none expected: col %0d row %0d",
                       out_data.led_column, out_data.led_row);
                fail_count++;
            end
            else
            begin
                want = led_expect.pop_front();
                check_field("led_column",    8'(want.led_column),  8'(out_data.led_column));
                check_field("led_row",       8'(want.led_row),     8'(out_data.led_row));
                check_field("red_out",       want.red_out,         out_data.red_out);
                check_field("green_out",     want.green_out,       out_data.green_out);
                check_field("blue_out",      want.blue_out,        out_data.blue_out);
                check_field("intensity_out", want.intensity_out,   out_data.intensity_out);
                check_field("last_update",   8'(want.last_update), 8'(out_data.last_update));
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Shadow starts at all 255 and the working frame at zero, so the first
    // mirror must touch every visible LED; a second one finds nothing.
    task automatic test_mirror_after_reset();
        send_beat(cmd_beat(REQ_MIRROR));
        send_beat(cmd_beat(REQ_MIRROR));
    endtask

    // Corner pixels, extreme values, two hidden-column writes and a write that
    // matches the shadow (no update for it).
    task automatic test_write_extremes();
        send_beat(pixel_beat(0, 0, PIX_FULL));
        send_beat(pixel_beat(DISP_W - 1, DISP_H - 1,
                             '{red: 8'h00, green: 8'hFF, blue: 8'h00, intensity: 8'hFF}));
        send_beat(pixel_beat(FRAME_COLS - 1, DISP_H - 1,
                             '{red: 8'hA5, green: 8'h5A, blue: 8'hC3, intensity: 8'h3C}));
        send_beat(pixel_beat(DISP_W, 0,
                             '{red: 8'h5A, green: 8'hA5, blue: 8'h3C, intensity: 8'hC3}));
        send_beat(pixel_beat(3, 3, PIX_ZERO));
        send_beat(pixel_beat(0, DISP_H - 1,
                             '{red: 8'hFF, green: 8'h00, blue: 8'hFF, intensity: 8'h00}));
        send_beat(cmd_beat(REQ_MIRROR));
    endtask

    // A pixel that differs from the shadow in one component only.
    task automatic test_single_component();
        send_beat(pixel_beat(2, 5,
                             '{red: 8'h00, green: 8'h00, blue: 8'h01, intensity: 8'h00}));
        send_beat(cmd_beat(REQ_MIRROR));
    endtask

    // Scroll pulls hidden columns into view and keeps the last column.
    task automatic test_scroll();
        send_beat(pixel_beat(FRAME_COLS - 1, 2,
                             '{red: 8'h12, green: 8'h34, blue: 8'h56, intensity: 8'h78}));
        send_beat(pixel_beat(DISP_W, 6,
                             '{red: 8'h9A, green: 8'hBC, blue: 8'hDE, intensity: 8'hF0}));
        send_beat(cmd_beat(REQ_SCROLL));
        send_beat(cmd_beat(REQ_SCROLL));
        send_beat(cmd_beat(REQ_SCROLL));
    endtask

    // Init clears everything and repaints every LED; a mirror after it is
    // quiet.
    task automatic test_init();
        send_beat(cmd_beat(REQ_INIT));
        send_beat(cmd_beat(REQ_MIRROR));
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly writes, with mirrors, scrolls and inits mixed
    // in. Written pixels are fully random, all-extreme components, a copy of
    // the current pixel with one component changed, or the shadowed value.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int beats, input int idle_pct,
                                       input int stall_pct);
        int   pick;
        int   col;
        int   row;
        int   comp;
        pix_t p;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (beats)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                col = $urandom_range(FRAME_COLS - 1);
                row = $urandom_range(DISP_H - 1);
                case ($urandom_range(3))
                    0:
                    begin
                        p = pix_t'($urandom);
                    end
                    1:
                    begin
                        p = {{8{1'($urandom)}}, {8{1'($urandom)}},
                             {8{1'($urandom)}}, {8{1'($urandom)}}};
                    end
                    2:
                    begin
                        p    = frame_work[col][row];
                        comp = $urandom_range(3);
                        p[comp*8 +: 8] = 8'($urandom);
                    end
                    default:
                    begin
                        p = (col < DISP_W) ? frame_shown[col][row] : frame_work[col][row];
                    end
                endcase
                send_beat(pixel_beat(col, row, p));
            end
            else if (pick < 77)
                send_beat(cmd_beat(REQ_MIRROR));
            else if (pick < 91)
                send_beat(cmd_beat(REQ_SCROLL));
            else
                send_beat(cmd_beat(REQ_INIT));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_frames();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_mirror_after_reset();
        test_write_extremes();
        test_single_component();
        test_scroll();
        test_init();

        test_random_traffic(84, 35, 88);
        test_random_traffic(84, 88, 35);
        test_random_traffic(84, 0, 0);
        drop_valid();

        // Drain outstanding updates, then let the block settle.
        while (led_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (led_expect.size() != 0)
        begin
            $error("%0d LED updates never arrived", led_expect.size());
            fail_count++;
        end

        $display("Covered %0d beats: %0d writes, %0d scrolls, %0d mirrors, %0d inits.",
                 beat_count, req_count[REQ_WRITE], req_count[REQ_SCROLL],
                 req_count[REQ_MIRROR], req_count[REQ_INIT]);
        $display("Checked %0d LED updates under three idle and stall mixes.",
                 update_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
